FILE: hdl/gjec_pkg.sv
`timescale 1ns / 1ps
// Package for the GPU job event correlator.
// Holds sizes, event and status codes and the pending-entry type; no dependencies.
package gjec_pkg;

  localparam int unsigned PendingEntries = 16;
  localparam int unsigned Timelines      = 16;
  localparam int unsigned MaxDepth       = 16;
  localparam int unsigned PendW  = $clog2(PendingEntries);
  localparam int unsigned RowW   = $clog2(MaxDepth);
  localparam int unsigned CountW = $clog2(MaxDepth + 1);
  localparam int unsigned TlIdxW = (Timelines > 1) ? $clog2(Timelines) : 1;
  localparam int unsigned RamDepth = Timelines * MaxDepth;
  localparam int unsigned RamAddrW = $clog2(RamDepth);
  localparam logic [31:0] SlackReset = 32'd1000000;

  typedef enum logic [1:0] {
    ActSubmit   = 2'd0,
    ActSchedule = 2'd1,
    ActFence    = 2'd2,
    ActUnused   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StsDone     = 2'd0,
    StsOverflow = 2'd1,
    StsDropped  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StSearch,
    StUpdate,
    StRowRead,
    StRowCheck,
    StRowWrite,
    StEmit
  } state_e;

  typedef struct packed {
    logic [2:0]  have;
    logic [31:0] ctx;
    logic [31:0] seq;
    logic [3:0]  tl;
    logic [21:0] thread;
    logic [63:0] t_submit;
    logic [63:0] t_sched;
    logic [63:0] t_fence;
  } entry_t;

  // Search token carried along the cell chain.
  typedef struct packed {
    logic            hit;
    logic [PendW:0]  slot;
    logic            free_ok;
    logic [PendW:0]  free_slot;
  } token_t;

endpackage

FILE: hdl/gjec_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the GPU job event correlator.
// Depends on nothing.
interface gjec_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] context_req;
  logic [31:0] seqno;
  logic [3:0]  timeline;
  logic [21:0] thread_id;
  logic [63:0] event_time;
  modport source (output valid, action, context_req, seqno, timeline, thread_id,
                  event_time, input ready);
  modport sink (input valid, action, context_req, seqno, timeline, thread_id,
                event_time, output ready);
endinterface

interface gjec_job_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [21:0] job_thread;
  logic [31:0] job_context;
  logic [31:0] job_seqno;
  logic [3:0]  job_timeline;
  logic [3:0]  depth;
  logic [63:0] submit_time;
  logic [63:0] schedule_time;
  logic [63:0] hw_start;
  logic [63:0] fence_time;
  modport source (output valid, status, job_thread, job_context, job_seqno, job_timeline,
                  depth, submit_time, schedule_time, hw_start, fence_time,
                  input ready);
  modport sink (input valid, status, job_thread, job_context, job_seqno, job_timeline,
                depth, submit_time, schedule_time, hw_start, fence_time,
                output ready);
endinterface

FILE: hdl/gpu_job_event_correlator.sv
`timescale 1ns / 1ps
// Top level of the GPU job event correlator: control, cell chain and row RAM.
// Depends on gjec_pkg, gjec_if, gjec_ram and gjec_cell.
//
//   Channel   Dir  Handshake    Payload
//   evt       in   valid/ready  action, key, thread_id, event time
//   job       out  valid/ready  status, key, depth, four times
//   slack     in   we only      slack_ns, 32 bits
//
// The search passes a token through the registered cell chain; an event that yields
// no result then returns to idle, ready for the next event. A completed job then
// scans its timeline's rows through the RAM port, reading and checking each row in
// turn, then writes the chosen row unless the timeline is full. Reset clears entry
// valid bits, row counts and latest fence times. A result waits in its register
// until taken; the next event is accepted only after the result is delivered.
module gpu_job_event_correlator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  gjec_event_if.sink  evt,
  gjec_job_if.source  job
);
  import gjec_pkg::*;

  state_e state_q, state_d;
  logic [31:0] slack_q;
  logic [1:0]  act_q;
  logic [31:0] ctx_q, seq_q;
  logic [3:0]  tl_q;
  logic [21:0] tid_q;
  logic [63:0] ts_q;
  logic [PendW+1:0] cnt_q, cnt_d;
  token_t      res_q;
  entry_t      cur_q;
  logic [PendW-1:0] slot_q;
  logic [CountW-1:0] rc_q [Timelines];
  logic [63:0] lf_q [Timelines];
  logic [CountW-1:0] row_q, row_d, n_cur;
  logic [TlIdxW-1:0] tli;
  logic        out_valid_q;
  logic [1:0]  o_status_q;
  logic [3:0]  o_depth_q;
  entry_t      o_ent_q;
  logic [63:0] o_hw_q;

  token_t tok [PendingEntries+1];
  entry_t ents [PendingEntries];
  logic   cell_we [PendingEntries];
  entry_t wdata;
  logic   upd_ok;

  logic        ram_we;
  logic [RamAddrW-1:0] ram_addr;
  logic [63:0] ram_rdata;
  logic [64:0] sum;
  logic        fits;

  assign tli   = tl_q[TlIdxW-1:0];
  assign n_cur = rc_q[tli];
  assign tok[0] = '0;
  assign upd_ok = res_q.hit ? !ents[slot_q].have[act_q] : res_q.free_ok;

  for (genvar g = 0; g < PendingEntries; g++) begin : g_cell
    gjec_cell u_cell (
      .clk_i, .rst_ni,
      .idx_i   ((PendW+1)'(g)),
      .ctx_i   (ctx_q),
      .seq_i   (seq_q),
      .tl_i    (tl_q),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1]),
      .we_i    (cell_we[g]),
      .wdata_i (wdata),
      .entry_o (ents[g])
    );
    assign cell_we[g] = (state_q == StUpdate) && upd_ok && (slot_q == PendW'(g));
  end

  assign ram_addr = RamAddrW'({tli, row_q[RowW-1:0]});
  assign sum  = {1'b0, ram_rdata} + {33'd0, slack_q};
  assign fits = !sum[64] && cur_q.t_submit >= sum[63:0];
  assign ram_we = (state_q == StRowWrite);

  gjec_ram #(.Width(64), .Depth(RamDepth)) u_rows (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(cur_q.t_fence), .rdata_o(ram_rdata)
  );

  // Entry update written during StUpdate.
  always_comb begin
    wdata = ents[slot_q];
    if (!res_q.hit) begin
      wdata.have = 3'd0;
      wdata.ctx  = ctx_q;
      wdata.seq  = seq_q;
      wdata.tl   = tl_q;
    end
    wdata.have = wdata.have | (3'd1 << act_q);
    case (act_q)
      ActSubmit: begin
        wdata.thread   = tid_q;
        wdata.t_submit = ts_q;
      end
      ActSchedule: wdata.t_sched = ts_q;
      default:     wdata.t_fence = ts_q;
    endcase
    if (wdata.have == 3'b111) begin
      wdata.have = 3'd0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    row_d   = row_q;
    case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (evt.valid) begin
          state_d = StSearch;
        end
      end
      StSearch: begin
        cnt_d = cnt_q + 1'b1;
        if (act_q == ActUnused || 32'(tl_q) >= Timelines) begin
          state_d = StIdle;
        end else if (cnt_q == (PendW+2)'(PendingEntries)) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        row_d = '0;
        if (!res_q.hit && !res_q.free_ok) begin
          state_d = StEmit;
        end else if (!upd_ok) begin
          state_d = StIdle;
        end else if (wdata.have == 3'd0) begin
          state_d = (n_cur == '0) ? StRowWrite : StRowRead;
        end else begin
          state_d = StIdle;
        end
      end
      StRowRead: state_d = StRowCheck;
      StRowCheck: begin
        if (fits) begin
          state_d = StRowWrite;
        end else if (row_q + 1'b1 < n_cur) begin
          row_d   = row_q + 1'b1;
          state_d = StRowRead;
        end else if (32'(n_cur) < MaxDepth) begin
          row_d   = n_cur;
          state_d = StRowWrite;
        end else begin
          state_d = StEmit;
        end
      end
      StRowWrite: state_d = StEmit;
      StEmit: begin
        if (out_valid_q && job.ready) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      slack_q     <= SlackReset;
      cnt_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < Timelines; i++) begin
        rc_q[i] <= '0;
        lf_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      row_q   <= row_d;
      if (cfg_we_i) begin
        slack_q <= cfg_wdata_i;
      end
      if (state_q == StRowWrite && row_q == n_cur) begin
        rc_q[tli] <= n_cur + 1'b1;
      end
      if ((state_q == StRowWrite || state_q == StRowCheck && state_d == StEmit)
          && cur_q.t_fence > lf_q[tli]) begin
        lf_q[tli] <= cur_q.t_fence;
      end
      if (state_q != StEmit && state_d == StEmit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && job.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && evt.valid) begin
      act_q <= evt.action;
      ctx_q <= evt.context_req;
      seq_q <= evt.seqno;
      tl_q  <= evt.timeline;
      tid_q <= evt.thread_id;
      ts_q  <= evt.event_time;
    end
    if (state_q == StSearch) begin
      res_q  <= tok[PendingEntries];
      slot_q <= tok[PendingEntries].hit ? tok[PendingEntries].slot[PendW-1:0]
                                        : tok[PendingEntries].free_slot[PendW-1:0];
    end
    if (state_q == StUpdate) begin
      cur_q <= wdata;
      o_hw_q <= (state_d == StEmit) ? 64'd0
                : ((wdata.t_sched < lf_q[tli]) ? lf_q[tli] : wdata.t_sched);
    end
    if (state_q != StEmit && state_d == StEmit) begin
      o_ent_q.ctx <= ctx_q;
      o_ent_q.seq <= seq_q;
      o_ent_q.tl  <= tl_q;
      if (state_q == StUpdate) begin
        o_status_q        <= StsDropped;
        o_depth_q         <= 4'd0;
        o_ent_q.thread    <= (act_q == ActSubmit) ? tid_q : 22'd0;
        o_ent_q.t_submit  <= (act_q == ActSubmit) ? ts_q : 64'd0;
        o_ent_q.t_sched   <= (act_q == ActSchedule) ? ts_q : 64'd0;
        o_ent_q.t_fence   <= (act_q == ActFence) ? ts_q : 64'd0;
      end else begin
        o_status_q        <= (state_q == StRowCheck) ? StsOverflow : StsDone;
        o_depth_q         <= (state_q == StRowCheck) ? 4'(MaxDepth - 1)
                             : ((32'(row_q) > 15) ? 4'd15 : 4'(row_q));
        o_ent_q.thread    <= cur_q.thread;
        o_ent_q.t_submit  <= cur_q.t_submit;
        o_ent_q.t_sched   <= cur_q.t_sched;
        o_ent_q.t_fence   <= cur_q.t_fence;
      end
    end
  end

  assign evt.ready         = (state_q == StIdle);
  assign job.valid         = out_valid_q;
  assign job.status        = o_status_q;
  assign job.job_thread    = o_ent_q.thread;
  assign job.job_context   = o_ent_q.ctx;
  assign job.job_seqno     = o_ent_q.seq;
  assign job.job_timeline  = o_ent_q.tl;
  assign job.depth         = o_depth_q;
  assign job.submit_time   = o_ent_q.t_submit;
  assign job.schedule_time = o_ent_q.t_sched;
  assign job.hw_start      = o_hw_q;
  assign job.fence_time    = o_ent_q.t_fence;

endmodule

FILE: hdl/gjec_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// Depends on nothing.
module gjec_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: hdl/gjec_cell.sv
`timescale 1ns / 1ps
// One pending-table cell: holds one entry and compares the key on the passing token.
// Depends on gjec_pkg.
module gjec_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [gjec_pkg::PendW:0]    idx_i,
  input  logic [31:0]                 ctx_i,
  input  logic [31:0]                 seq_i,
  input  logic [3:0]                  tl_i,
  input  gjec_pkg::token_t            tok_i,
  output gjec_pkg::token_t            tok_o,
  input  logic                        we_i,
  input  gjec_pkg::entry_t            wdata_i,
  output gjec_pkg::entry_t            entry_o
);
  import gjec_pkg::*;

  logic [2:0] have_q;
  entry_t  dat_q;
  token_t  tok_d, tok_q;

  always_comb begin
    tok_d = tok_i;
    if (have_q != 3'd0) begin
      if (!tok_i.hit && dat_q.ctx == ctx_i && dat_q.seq == seq_i && dat_q.tl == tl_i) begin
        tok_d.hit  = 1'b1;
        tok_d.slot = idx_i;
      end
    end else if (!tok_i.free_ok) begin
      tok_d.free_ok   = 1'b1;
      tok_d.free_slot = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 3'd0;
      tok_q  <= '0;
    end else begin
      tok_q <= tok_d;
      if (we_i) begin
        have_q <= wdata_i.have;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      dat_q <= wdata_i;
    end
  end

  always_comb begin
    entry_o      = dat_q;
    entry_o.have = have_q;
  end

  assign tok_o = tok_q;

endmodule
